@@ rtl/core/adsr_pkg.sv @@
// ---------------------------------------------------------------------------
// ADSR envelope package
// Segment encoding, register indexes and reset values shared by the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package adsr_pkg;

    localparam int FRAC_BITS_DEFAULT = 24;
    localparam int CFG_INDEX_W       = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_COEFF  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_TARGET = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DECAY_COEFF   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_COEFF = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SUSTAIN_LEVEL = 3'd4;

    // Reset values in Q24; rescaled to the configured fraction width
    localparam longint ATTACK_COEFF_Q24  = 16128;
    localparam longint ATTACK_TARGET_Q24 = 16944988;
    localparam longint DECAY_COEFF_Q24   = 3495;
    localparam longint RELEASE_COEFF_Q24 = 3495;
    localparam longint SUSTAIN_LEVEL_Q24 = 11744051;

    // Segment codes on the output port
    localparam logic [1:0] SEG_CODE_IDLE    = 2'd0;
    localparam logic [1:0] SEG_CODE_ATTACK  = 2'd1;
    localparam logic [1:0] SEG_CODE_DECAY   = 2'd2;
    localparam logic [1:0] SEG_CODE_RELEASE = 2'd3;

    typedef enum logic [3:0] {
        SEG_IDLE    = 4'b0001,
        SEG_ATTACK  = 4'b0010,
        SEG_DECAY   = 4'b0100,
        SEG_RELEASE = 4'b1000
    } seg_t;

    function automatic longint scale_q24(input longint v, input int frac_bits);
        longint r;
        if (frac_bits >= 24)
        begin
            r = v << (frac_bits - 24);
        end
        else
        begin
            r = v >> (24 - frac_bits);
        end
        return r;
    endfunction

    function automatic logic [1:0] seg_code(input seg_t s);
        logic [1:0] c;
        unique case (s)
            SEG_IDLE:    c = SEG_CODE_IDLE;
            SEG_ATTACK:  c = SEG_CODE_ATTACK;
            SEG_DECAY:   c = SEG_CODE_DECAY;
            SEG_RELEASE: c = SEG_CODE_RELEASE;
            default:     c = SEG_CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/adsr_envelope_generator.sv @@
// ---------------------------------------------------------------------------
// ADSR envelope generator
// One-pole exponential attack/decay/sustain/release envelope, one sample
// per request, unsigned fixed point with FRAC_BITS fraction bits.
// ---------------------------------------------------------------------------
// For each request the retrigger, gate edge, one multiply-add of
// coeff * (target - level) and the segment clamps are all evaluated in the
// accepting cycle from the state registers and land in the output register.
// A new request is taken every cycle; the input stalls only while the output
// register holds a result that the downstream side is stalling. out_valid
// rises in the cycle after accept and is set by the single output
// register. The critical path is the (FRAC_BITS+4) x (FRAC_BITS+1) multiplier
// followed by the rounding add and level update. Configuration writes are
// always accepted (cfg_ready is tied high) and must be issued only while no
// request is in flight. Sustain writes at or below zero store -0.01, writes
// above one store one; coefficient writes above one are used as one.
`timescale 1ns / 1ps
`default_nettype none

module adsr_envelope_generator #(
    parameter int FRAC_BITS = adsr_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [adsr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [FRAC_BITS+3:0]              cfg_data,
    // input channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              gate_in,
    input  wire logic                              retrigger,
    input  wire logic                              hard_retrigger,
    // output channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [FRAC_BITS:0]                     envelope,
    output logic [1:0]                             segment
);
    import adsr_pkg::*;

    localparam int DW = FRAC_BITS + 5;          // signed diff width
    localparam int PW = 2 * FRAC_BITS + 5;      // product width
    localparam int LW = FRAC_BITS + 6;          // signed updated level width

    localparam longint OneL          = longint'(1) << FRAC_BITS;
    localparam longint NegHundredthL = (OneL + 50) / 100;

    localparam logic [FRAC_BITS:0]          One       = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [FRAC_BITS+1:0] SusOne    = {2'b01, {FRAC_BITS{1'b0}}};
    localparam logic signed [FRAC_BITS+1:0] SusNegH   = (FRAC_BITS+2)'(-NegHundredthL);
    localparam logic signed [DW-1:0]        TgtRel    = DW'(-NegHundredthL);
    localparam logic signed [LW-1:0]        OneWide   = {6'b000001, {FRAC_BITS{1'b0}}};
    localparam logic [PW-1:0]               Half      =
        {{(FRAC_BITS+5){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    localparam logic [FRAC_BITS:0]   AttackCoeffRst  =
        (FRAC_BITS+1)'(scale_q24(ATTACK_COEFF_Q24, FRAC_BITS));
    localparam logic [FRAC_BITS+3:0] AttackTargetRst =
        (FRAC_BITS+4)'(scale_q24(ATTACK_TARGET_Q24, FRAC_BITS));
    localparam logic [FRAC_BITS:0]   DecayCoeffRst   =
        (FRAC_BITS+1)'(scale_q24(DECAY_COEFF_Q24, FRAC_BITS));
    localparam logic [FRAC_BITS:0]   ReleaseCoeffRst =
        (FRAC_BITS+1)'(scale_q24(RELEASE_COEFF_Q24, FRAC_BITS));
    localparam logic [FRAC_BITS+1:0] SustainRst      =
        (FRAC_BITS+2)'(scale_q24(SUSTAIN_LEVEL_Q24, FRAC_BITS));

    // configuration registers
    logic [FRAC_BITS:0]          attack_coeff_reg;
    logic [FRAC_BITS+3:0]        attack_target_reg;
    logic [FRAC_BITS:0]          decay_coeff_reg;
    logic [FRAC_BITS:0]          release_coeff_reg;
    logic signed [FRAC_BITS+1:0] sustain_reg;

    // envelope state
    logic [FRAC_BITS:0] level_reg, level_next;
    seg_t               seg_reg, seg_next;
    logic               prev_gate_reg;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [FRAC_BITS:0] envelope_reg, envelope_next;
    logic [1:0]         segment_reg;

    logic                          accept;
    logic                          cfg_write;
    logic [FRAC_BITS:0]            wr_coeff;
    logic signed [FRAC_BITS+1:0]   wr_sus_raw;
    logic signed [FRAC_BITS+1:0]   wr_sus;

    seg_t                  seg_pre;
    logic [FRAC_BITS:0]    lvl_pre;
    logic [FRAC_BITS:0]    coeff;
    logic signed [DW-1:0]  target;
    logic signed [DW-1:0]  diff;
    logic                  diff_neg;
    logic [DW-2:0]         mag;
    logic [PW-1:0]         prod_rnd;
    logic [FRAC_BITS+4:0]  step;
    logic signed [LW-1:0]  lvl_wide;
    logic signed [LW-1:0]  step_wide;
    logic signed [LW-1:0]  lvl_new;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    // Clamp coefficient and sustain writes to their legal ranges
    always_comb
    begin
        wr_coeff   = (cfg_data[FRAC_BITS:0] > One) ? One : cfg_data[FRAC_BITS:0];
        wr_sus_raw = signed'(cfg_data[FRAC_BITS+1:0]);
        if (wr_sus_raw <= 0)
        begin
            wr_sus = SusNegH;
        end
        else if (wr_sus_raw > SusOne)
        begin
            wr_sus = SusOne;
        end
        else
        begin
            wr_sus = wr_sus_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_coeff_reg  <= AttackCoeffRst;
            attack_target_reg <= AttackTargetRst;
            decay_coeff_reg   <= DecayCoeffRst;
            release_coeff_reg <= ReleaseCoeffRst;
            sustain_reg       <= SustainRst;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ATTACK_COEFF:  attack_coeff_reg  <= wr_coeff;
                REG_ATTACK_TARGET: attack_target_reg <= cfg_data;
                REG_DECAY_COEFF:   decay_coeff_reg   <= wr_coeff;
                REG_RELEASE_COEFF: release_coeff_reg <= wr_coeff;
                REG_SUSTAIN_LEVEL: sustain_reg       <= wr_sus;
                default:           ;
            endcase
        end
    end

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    // Retrigger first, then gate edges
    always_comb
    begin
        seg_pre = seg_reg;
        if (retrigger)
        begin
            seg_pre = SEG_ATTACK;
        end
        priority if (gate_in && !prev_gate_reg)
        begin
            seg_pre = SEG_ATTACK;
        end
        else if (!gate_in && prev_gate_reg)
        begin
            seg_pre = SEG_RELEASE;
        end
        else
        begin
            seg_pre = seg_pre;
        end
        lvl_pre = (retrigger && hard_retrigger) ? '0 : level_reg;
    end

    // One-pole step: level += round(coeff * (target - level))
    always_comb
    begin
        unique case (seg_pre)
            SEG_ATTACK:
            begin
                coeff  = attack_coeff_reg;
                target = signed'({1'b0, attack_target_reg});
            end
            SEG_DECAY:
            begin
                coeff  = decay_coeff_reg;
                target = DW'(sustain_reg);
            end
            SEG_RELEASE:
            begin
                coeff  = release_coeff_reg;
                target = TgtRel;
            end
            default:
            begin
                coeff  = '0;
                target = '0;
            end
        endcase

        diff      = target - signed'({4'b0000, lvl_pre});
        diff_neg  = diff[DW-1];
        mag       = diff_neg ? (DW-1)'(-diff) : diff[DW-2:0];
        prod_rnd  = PW'(mag) * PW'(coeff) + Half;
        step      = prod_rnd[PW-1:FRAC_BITS];
        lvl_wide  = signed'({5'b00000, lvl_pre});
        step_wide = signed'({1'b0, step});
        lvl_new   = diff_neg ? (lvl_wide - step_wide) : (lvl_wide + step_wide);
    end

    // Segment clamps and exits
    always_comb
    begin
        seg_next      = seg_pre;
        level_next    = lvl_pre;
        envelope_next = '0;
        unique case (seg_pre)
            SEG_ATTACK:
            begin
                if (lvl_new > OneWide)
                begin
                    level_next = One;
                    seg_next   = SEG_DECAY;
                end
                else
                begin
                    level_next = lvl_new[FRAC_BITS:0];
                end
                envelope_next = level_next;
            end
            SEG_DECAY, SEG_RELEASE:
            begin
                if (lvl_new[LW-1])
                begin
                    level_next = '0;
                    seg_next   = SEG_IDLE;
                end
                else
                begin
                    level_next = lvl_new[FRAC_BITS:0];
                end
                envelope_next = level_next;
            end
            default:
            begin
                // idle: hold the level, drive zero
                envelope_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            seg_reg       <= SEG_IDLE;
            prev_gate_reg <= 1'b0;
        end
        else if (accept)
        begin
            level_reg     <= level_next;
            seg_reg       <= seg_next;
            prev_gate_reg <= gate_in;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg & out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            envelope_reg <= envelope_next;
            segment_reg  <= seg_code(seg_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign envelope  = envelope_reg;
    assign segment   = segment_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= One)
        else $error("level above one");

    a_accept_valid: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted request produced no result");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (segment_reg == SEG_CODE_IDLE) |-> (envelope_reg == '0))
        else $error("nonzero envelope while idle");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with empty output register");

endmodule

`default_nettype wire

@@ verif/adsr_checker.sv @@
// ---------------------------------------------------------------------------
// ADSR envelope checker
// Watches the configuration, request and result channels of the envelope
// generator, predicts every envelope sample and compares it field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module adsr_checker #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    input  wire logic                              cfg_ready,
    input  wire logic [adsr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [FRAC_BITS+3:0]              cfg_data,
    input  wire logic                              in_valid,
    input  wire logic                              in_stall,
    input  wire logic                              gate_in,
    input  wire logic                              retrigger,
    input  wire logic                              hard_retrigger,
    input  wire logic                              out_valid,
    input  wire logic                              out_stall,
    input  wire logic [FRAC_BITS:0]                envelope,
    input  wire logic [1:0]                        segment,
    output int                                     mismatch_count,
    output int                                     pending_count
);

    import adsr_pkg::*;

    localparam longint ONE         = longint'(1) << FRAC_BITS;
    localparam longint FLOOR_LEVEL = -((ONE + 50) / 100);

    typedef struct packed {
        logic [FRAC_BITS:0] envelope;
        logic [1:0]         segment;
    } env_sample_t;

    env_sample_t expected_samples[$];
    int          errors;

    // predicted register file and envelope state
    longint     atk_coeff;
    longint     atk_target;
    longint     dec_coeff;
    longint     rel_coeff;
    longint     sustain;
    longint     level;
    logic [1:0] seg_now;
    logic       gate_prev;

    function automatic longint clamp_coeff(input logic [FRAC_BITS+3:0] v);
        longint c;
        c = longint'(v[FRAC_BITS:0]);
        return (c > ONE) ? ONE : c;
    endfunction

    function automatic longint clamp_sustain(input logic [FRAC_BITS+3:0] v);
        logic signed [FRAC_BITS+1:0] raw;
        longint s;
        raw = v[FRAC_BITS+1:0];
        s   = longint'(raw);
        if (s <= 0)
        begin
            s = FLOOR_LEVEL;
        end
        else if (s > ONE)
        begin
            s = ONE;
        end
        return s;
    endfunction

    // coeff * diff / ONE, rounded to nearest with ties away from zero
    function automatic longint rounded_step(input longint coeff, input longint diff);
        longint mag;
        longint r;
        mag = (diff < 0) ? -diff : diff;
        r   = (mag * coeff + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        return (diff < 0) ? -r : r;
    endfunction

    task automatic step_envelope(input logic g, input logic r, input logic h,
                                 output env_sample_t res);
        longint env;
        longint coeff;
        longint target;
        env = 0;
        if (r)
        begin
            seg_now = SEG_CODE_ATTACK;
            if (h)
            begin
                level = 0;
            end
        end
        if (g && !gate_prev)
        begin
            seg_now = SEG_CODE_ATTACK;
        end
        else if (!g && gate_prev)
        begin
            seg_now = SEG_CODE_RELEASE;
        end
        gate_prev = g;

        if (seg_now == SEG_CODE_ATTACK)
        begin
            level = level + rounded_step(atk_coeff, atk_target - level);
            if (level > ONE)
            begin
                level   = ONE;
                seg_now = SEG_CODE_DECAY;
            end
            env = level;
        end
        else if (seg_now == SEG_CODE_DECAY || seg_now == SEG_CODE_RELEASE)
        begin
            coeff  = (seg_now == SEG_CODE_DECAY) ? dec_coeff : rel_coeff;
            target = (seg_now == SEG_CODE_DECAY) ? sustain : FLOOR_LEVEL;
            level  = level + rounded_step(coeff, target - level);
            if (level < 0)
            begin
                level   = 0;
                seg_now = SEG_CODE_IDLE;
            end
            env = level;
        end

        if (env < 0)
        begin
            env = 0;
        end
        res.envelope = env[FRAC_BITS:0];
        res.segment  = seg_now;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        env_sample_t want;
        env_sample_t fresh;
        if (!rst_n)
        begin
            atk_coeff  = ATTACK_COEFF_Q24;
            atk_target = ATTACK_TARGET_Q24;
            dec_coeff  = DECAY_COEFF_Q24;
            rel_coeff  = RELEASE_COEFF_Q24;
            sustain    = SUSTAIN_LEVEL_Q24;
            level      = 0;
            seg_now    = SEG_CODE_IDLE;
            gate_prev  = 1'b0;
            errors     = 0;
            expected_samples.delete();
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: result with no request waiting, envelope %0d segment %0d",
                             $time, envelope, segment);
                    errors++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (envelope !== want.envelope)
                    begin
                        $display("%0t: envelope mismatch, expected %0d, actual %0d",
                                 $time, want.envelope, envelope);
                        errors++;
                    end
                    if (segment !== want.segment)
                    begin
                        $display("%0t: segment mismatch, expected %0d, actual %0d",
                                 $time, want.segment, segment);
                        errors++;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ATTACK_COEFF:  atk_coeff  = clamp_coeff(cfg_data);
                    REG_ATTACK_TARGET: atk_target = longint'(cfg_data);
                    REG_DECAY_COEFF:   dec_coeff  = clamp_coeff(cfg_data);
                    REG_RELEASE_COEFF: rel_coeff  = clamp_coeff(cfg_data);
                    REG_SUSTAIN_LEVEL: sustain    = clamp_sustain(cfg_data);
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                step_envelope(gate_in, retrigger, hard_retrigger, fresh);
                expected_samples.push_back(fresh);
            end

            mismatch_count <= errors;
            pending_count  <= expected_samples.size();
        end
    end

endmodule

@@ verif/tb_top.sv @@
// ---------------------------------------------------------------------------
// ADSR envelope generator testbench
// Drives note gates and retriggers under several register settings and
// random back-pressure; the checker beside the block predicts every sample.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import adsr_pkg::*;

    localparam int FRAC_BITS      = 24;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int BLOCKS         = 7;
    localparam int BLOCK_ITEMS    = 50;

    localparam logic [FRAC_BITS+3:0] Q_ONE      = 28'd16777216;
    localparam logic [FRAC_BITS+3:0] Q_ALL_ONES = 28'hFFFFFFF;
    localparam logic [FRAC_BITS+3:0] Q_TOP      = 28'd172966789;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [FRAC_BITS+3:0]    cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic                    gate_in;
    logic                    retrigger;
    logic                    hard_retrigger;
    logic                    out_valid;
    logic                    out_stall;
    logic [FRAC_BITS:0]      envelope;
    logic [1:0]              segment;

    int mismatch_count;
    int pending_count;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    adsr_envelope_generator #(
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .gate_in        (gate_in),
        .retrigger      (retrigger),
        .hard_retrigger (hard_retrigger),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .envelope       (envelope),
        .segment        (segment)
    );

    adsr_checker #(
        .FRAC_BITS (FRAC_BITS)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .gate_in        (gate_in),
        .retrigger      (retrigger),
        .hard_retrigger (hard_retrigger),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .envelope       (envelope),
        .segment        (segment),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // downstream back-pressure
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // end the run when no channel has moved for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_sample(input logic g, input logic r, input logic h);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid       <= 1'b1;
        gate_in        <= g;
        retrigger      <= r;
        hard_retrigger <= h;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // drop the request line and wait for every outstanding sample
    task automatic drain_samples();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [FRAC_BITS+3:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_regs(input logic [FRAC_BITS+3:0] ac, input logic [FRAC_BITS+3:0] at,
                             input logic [FRAC_BITS+3:0] dc, input logic [FRAC_BITS+3:0] rc,
                             input logic [FRAC_BITS+3:0] sl);
        drain_samples();
        write_reg(REG_ATTACK_COEFF, ac);
        write_reg(REG_ATTACK_TARGET, at);
        write_reg(REG_DECAY_COEFF, dc);
        write_reg(REG_RELEASE_COEFF, rc);
        write_reg(REG_SUSTAIN_LEVEL, sl);
    endtask

    function automatic logic [FRAC_BITS+3:0] pick_coeff();
        logic [FRAC_BITS+3:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = Q_ONE;
            2:       v = (FRAC_BITS+4)'($urandom);
            default: v = (FRAC_BITS+4)'($urandom_range(Q_ONE / 16, Q_ONE));
        endcase
        return v;
    endfunction

    function automatic logic [FRAC_BITS+3:0] pick_target();
        logic [FRAC_BITS+3:0] v;
        case ($urandom_range(0, 7))
            0:       v = Q_ONE;
            1:       v = Q_TOP;
            2:       v = (FRAC_BITS+4)'($urandom);
            3:       v = (FRAC_BITS+4)'($urandom_range(0, Q_ONE));
            default: v = (FRAC_BITS+4)'(Q_ONE + $urandom_range(1, Q_ONE / 4));
        endcase
        return v;
    endfunction

    function automatic logic [FRAC_BITS+3:0] pick_sustain();
        logic [FRAC_BITS+3:0] v;
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = {4'hF, 1'b1, 23'($urandom)};
            2:       v = Q_ONE;
            3:       v = (FRAC_BITS+4)'($urandom);
            default: v = (FRAC_BITS+4)'($urandom_range(1, Q_ONE));
        endcase
        return v;
    endfunction

    // notes: gate held then released, with occasional retriggers and noise
    task automatic play_notes(input int count);
        int sent;
        int hold;
        int rest;
        int i;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                hold = $urandom_range(1, 30);
                rest = $urandom_range(1, 30);
                for (i = 0; i < hold && sent < count; i++)
                begin
                    send_sample(1'b1, $urandom_range(0, 19) == 0, 1'($urandom_range(0, 1)));
                    sent++;
                end
                for (i = 0; i < rest && sent < count; i++)
                begin
                    send_sample(1'b0, 1'b0, $urandom_range(0, 9) == 0);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin : stimulus
        int phase;
        int blk;
        int i;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        gate_in        = 1'b0;
        retrigger      = 1'b0;
        hard_retrigger = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: idle sample, lone hard flag, slow attack, hard restart, release
        send_sample(1'b0, 1'b0, 1'b0);
        send_sample(1'b0, 1'b0, 1'b1);
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b1, 1'b1, 1'b1);
        send_sample(1'b0, 1'b0, 1'b0);

        // an oversized attack coefficient acts as one; sustain of zero decays to idle
        load_regs(Q_ALL_ONES, Q_ALL_ONES, Q_ONE / 2, Q_ONE, '0);
        for (i = 0; i < 9; i++)
        begin
            send_sample(1'b1, 1'b0, 1'b0);
        end
        send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b0, 1'b1, 1'b0);

        // attack aimed at exactly one reaches one but never exceeds it, so it stays in attack
        load_regs(Q_ONE - 1, Q_ONE, '0, '0, 28'h1FFFFFF);
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b0, 1'b0, 1'b0);

        // sustain clamped to one holds the decay at full scale
        load_regs(Q_ONE, Q_TOP, Q_ONE / 4, Q_ONE / 8, 28'h1FFFFFF);
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b0, 1'b0, 1'b0);
        send_sample(1'b0, 1'b0, 1'b0);

        for (phase = 0; phase < 3; phase++)
        begin
            drain_samples();
            case (phase)
                0:
                begin
                    send_idle_pct  = 30;
                    recv_stall_pct = 70;
                end
                1:
                begin
                    send_idle_pct  = 70;
                    recv_stall_pct = 30;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (blk = 0; blk < BLOCKS; blk++)
            begin
                load_regs(pick_coeff(), pick_target(), pick_coeff(), pick_coeff(),
                          pick_sustain());
                play_notes(BLOCK_ITEMS);
            end
        end

        drain_samples();
        repeat (4) @(negedge clk);
        if (mismatch_count == 0 && pending_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
